// File: hw/rtl/rbst_pkg.sv
package rbst_pkg;

  // Coordinate format: signed Q(CW-FB).FB
  localparam int CW = 32;
  localparam int FB = 16;
  // Quotient bits below saturation
  localparam int QB = CW - 1;
  // Width of the shifted dividend (|bound - origin| << FB)
  localparam int NW = CW + 1 + FB;

  typedef logic signed [CW-1:0] coord_t;

  // One divider lane in flight
  typedef struct packed {
    logic [CW-1:0] rem;
    logic [CW-1:0] den;
    logic [QB-1:0] num;
    logic [QB-1:0] quo;
    logic          neg;
    logic          sat;
  } div_t;

  // Per-item flags carried beside the data
  typedef struct packed {
    logic       in_box;
    logic       miss;
    logic [2:0] zax;
  } flag_t;

  localparam coord_t T_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t T_MAX = {1'b0, {(CW-1){1'b1}}};

  // One restoring division step: shift in a dividend bit, try a subtract
  function automatic div_t div_step(div_t a);
    logic [CW:0] r2;
    logic [CW:0] df;
    div_t        b;
    r2 = {a.rem, a.num[QB-1]};
    df = r2 - {1'b0, a.den};
    b = a;
    if (!df[CW]) begin
      b.rem = df[CW-1:0];
      b.quo = {a.quo[QB-2:0], 1'b1};
    end else begin
      b.rem = r2[CW-1:0];
      b.quo = {a.quo[QB-2:0], 1'b0};
    end
    b.num = a.num << 1;
    return b;
  endfunction

endpackage

// File: hw/rtl/ray_box_slab_test.sv
// Channel | Signals                                    | Direction
// --------+--------------------------------------------+----------
// in      | in_valid, in_stall, origin_*, dir_*, box_* | into block
// out     | out_valid, out_stall, hit                  | out of block
//
// One item per clock while no stalled result holds the pipeline.
// The pipeline length is set by the six restoring dividers, one quotient bit per stage.
// Synchronous active-high rst clears all valid bits; payload is not reset.
// A stalled result freezes the whole pipeline, so in_stall follows it.
module ray_box_slab_test (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rbst_pkg::coord_t     origin_x,
  input  rbst_pkg::coord_t     origin_y,
  input  rbst_pkg::coord_t     origin_z,
  input  rbst_pkg::coord_t     dir_x,
  input  rbst_pkg::coord_t     dir_y,
  input  rbst_pkg::coord_t     dir_z,
  input  rbst_pkg::coord_t     box_min_x,
  input  rbst_pkg::coord_t     box_min_y,
  input  rbst_pkg::coord_t     box_min_z,
  input  rbst_pkg::coord_t     box_max_x,
  input  rbst_pkg::coord_t     box_max_y,
  input  rbst_pkg::coord_t     box_max_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit
);

  localparam int CW = rbst_pkg::CW;
  localparam int QB = rbst_pkg::QB;
  localparam int NW = rbst_pkg::NW;

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  rbst_pkg::coord_t org [3];
  rbst_pkg::coord_t dir [3];
  rbst_pkg::coord_t bmin [3];
  rbst_pkg::coord_t bmax [3];

  always_comb begin
    org[0] = origin_x;  org[1] = origin_y;  org[2] = origin_z;
    dir[0] = dir_x;     dir[1] = dir_y;     dir[2] = dir_z;
    bmin[0] = box_min_x; bmin[1] = box_min_y; bmin[2] = box_min_z;
    bmax[0] = box_max_x; bmax[1] = box_max_y; bmax[2] = box_max_z;
  end

  // Stage 1: bound differences, divisor magnitudes, inside and zero-axis tests
  logic signed [CW:0] s1_diff [6];
  logic [CW-1:0]      s1_dm [3];
  logic [2:0]         s1_dneg;
  rbst_pkg::flag_t    s1_flag;
  logic               s1_valid;

  logic signed [CW:0] c1_diff [6];
  logic [CW-1:0]      c1_dm [3];
  rbst_pkg::flag_t    c1_flag;

  always_comb begin
    c1_flag.in_box = 1'b1;
    c1_flag.miss = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      c1_diff[2*ax]   = {bmin[ax][CW-1], bmin[ax]} - {org[ax][CW-1], org[ax]};
      c1_diff[2*ax+1] = {bmax[ax][CW-1], bmax[ax]} - {org[ax][CW-1], org[ax]};
      c1_dm[ax] = dir[ax][CW-1] ? (CW'(0) - dir[ax]) : dir[ax];
      c1_flag.zax[ax] = (dir[ax] == '0);
      if (!(org[ax] >= bmin[ax] && org[ax] < bmax[ax]))
        c1_flag.in_box = 1'b0;
      if (c1_flag.zax[ax] && !(org[ax] >= bmin[ax] && org[ax] <= bmax[ax]))
        c1_flag.miss = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_diff <= c1_diff;
      s1_dm   <= c1_dm;
      s1_flag <= c1_flag;
      for (int ax = 0; ax < 3; ax++) s1_dneg[ax] <= dir[ax][CW-1];
    end
  end

  // Stage 2: numerator magnitudes and quotient signs
  logic [CW:0]     s2_m [6];
  logic [5:0]      s2_neg;
  logic [CW-1:0]   s2_dm [3];
  rbst_pkg::flag_t s2_flag;
  logic            s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 6; l++) begin
        s2_m[l]   <= s1_diff[l][CW] ? ((CW+1)'(0) - s1_diff[l]) : s1_diff[l];
        s2_neg[l] <= s1_diff[l][CW] ^ s1_dneg[l/2];
      end
      s2_dm   <= s1_dm;
      s2_flag <= s1_flag;
    end
  end

  // Stage 3: saturation check and divider load; then one quotient bit per stage
  rbst_pkg::div_t  dv [QB+1][6];
  rbst_pkg::flag_t dflag [QB+1];
  logic [QB:0]     dvv;

  logic [NW-1:0]    c3_n [6];
  logic [CW+QB-1:0] c3_lhs [6];
  logic [CW+QB-1:0] c3_rhs [6];

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      c3_n[l]   = NW'(s2_m[l]) << rbst_pkg::FB;
      c3_lhs[l] = (CW+QB)'(c3_n[l]);
      c3_rhs[l] = (CW+QB)'(s2_dm[l/2]) << QB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 6; l++) begin
        dv[0][l].rem <= CW'(c3_n[l][NW-1:QB]);
        dv[0][l].den <= s2_dm[l/2];
        dv[0][l].num <= c3_n[l][QB-1:0];
        dv[0][l].quo <= '0;
        dv[0][l].neg <= s2_neg[l];
        dv[0][l].sat <= (c3_lhs[l] >= c3_rhs[l]);
      end
      dflag[0] <= s2_flag;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (adv) begin
        dvv[k+1] <= dvv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 6; l++) dv[k+1][l] <= rbst_pkg::div_step(dv[k][l]);
        dflag[k+1] <= dflag[k];
      end
    end
  end

  // Stage 4: sign and saturation applied to each distance
  rbst_pkg::coord_t s4_t [6];
  rbst_pkg::flag_t  s4_flag;
  logic             s4_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= dvv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 6; l++) begin
        if (dv[QB][l].neg)
          s4_t[l] <= dv[QB][l].sat ? rbst_pkg::T_MIN : (CW'(0) - CW'(dv[QB][l].quo));
        else
          s4_t[l] <= dv[QB][l].sat ? rbst_pkg::T_MAX : CW'(dv[QB][l].quo);
      end
      s4_flag <= dflag[QB];
    end
  end

  // Stage 5: per-axis entry and exit; a zero-direction axis is unbounded
  rbst_pkg::coord_t s5_en [3];
  rbst_pkg::coord_t s5_ex [3];
  rbst_pkg::flag_t  s5_flag;
  logic             s5_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ax = 0; ax < 3; ax++) begin
        if (s4_flag.zax[ax]) begin
          s5_en[ax] <= rbst_pkg::T_MIN;
          s5_ex[ax] <= rbst_pkg::T_MAX;
        end else if (s4_t[2*ax] < s4_t[2*ax+1]) begin
          s5_en[ax] <= s4_t[2*ax];
          s5_ex[ax] <= s4_t[2*ax+1];
        end else begin
          s5_en[ax] <= s4_t[2*ax+1];
          s5_ex[ax] <= s4_t[2*ax];
        end
      end
      s5_flag <= s4_flag;
    end
  end

  // Stage 6: largest entry, smallest exit
  rbst_pkg::coord_t s6_entry;
  rbst_pkg::coord_t s6_exit;
  rbst_pkg::flag_t  s6_flag;
  logic             s6_valid;
  rbst_pkg::coord_t c6_en01;
  rbst_pkg::coord_t c6_ex01;

  always_comb begin
    c6_en01 = (s5_en[0] > s5_en[1]) ? s5_en[0] : s5_en[1];
    c6_ex01 = (s5_ex[0] < s5_ex[1]) ? s5_ex[0] : s5_ex[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_entry <= (c6_en01 > s5_en[2]) ? c6_en01 : s5_en[2];
      s6_exit  <= (c6_ex01 < s5_ex[2]) ? c6_ex01 : s5_ex[2];
      s6_flag  <= s5_flag;
    end
  end

  // Output register: final hit decision
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= s6_flag.in_box ||
             (!s6_flag.miss && !s6_exit[CW-1] && (s6_entry <= s6_exit) &&
              !s6_entry[CW-1] && (s6_entry != '0));
    end
  end

  // Checks
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted transfer did not enter stage 1");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(dvv) && $stable(s1_valid) && $stable(s6_valid))
    else $error("pipeline moved while output stalled");

  a_inside_hits: assert property (@(posedge clk) disable iff (rst)
    adv && s6_valid && s6_flag.in_box |=> out_valid && hit)
    else $error("origin inside box but no hit");

  a_order_miss: assert property (@(posedge clk) disable iff (rst)
    adv && s6_valid && !s6_flag.in_box && (s6_entry > s6_exit) |=> out_valid && !hit)
    else $error("entry beyond exit reported as hit");

endmodule
